@@ design/tlca_pkg.sv @@
// ----------------------------------------------------------------------------
// tlca_pkg : shared definitions for the closest-approach vertex block
// Default widths, pipeline control bundle and a width helper.
// ----------------------------------------------------------------------------
package tlca_pkg;

  localparam int POS_WIDTH_DEF = 24;
  localparam int DIR_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  // pipeline control, from the controller to the datapath
  typedef struct packed {
    logic en;       // advance every stage
    logic skid_ld;  // park the last stage in the skid register
    logic skid_v;   // skid register holds an item
    logic out_v;    // an item is offered on the result channel
  } ctl_t;

  function automatic int wmax(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

endpackage

@@ design/tlca_if.sv @@
// ----------------------------------------------------------------------------
// tlca_if : line pair and vertex channels
// Valid/ready channels carrying one line pair and one vertex item.
// ----------------------------------------------------------------------------
interface tlca_in_if #(
  parameter int POS_WIDTH = tlca_pkg::POS_WIDTH_DEF,
  parameter int DIR_WIDTH = tlca_pkg::DIR_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] first_point_x;
  logic signed [POS_WIDTH-1:0] first_point_y;
  logic signed [POS_WIDTH-1:0] first_point_z;
  logic signed [DIR_WIDTH-1:0] first_dir_x;
  logic signed [DIR_WIDTH-1:0] first_dir_y;
  logic signed [DIR_WIDTH-1:0] first_dir_z;
  logic signed [POS_WIDTH-1:0] second_point_x;
  logic signed [POS_WIDTH-1:0] second_point_y;
  logic signed [POS_WIDTH-1:0] second_point_z;
  logic signed [DIR_WIDTH-1:0] second_dir_x;
  logic signed [DIR_WIDTH-1:0] second_dir_y;
  logic signed [DIR_WIDTH-1:0] second_dir_z;

  modport source (
    output valid, first_point_x, first_point_y, first_point_z,
           first_dir_x, first_dir_y, first_dir_z,
           second_point_x, second_point_y, second_point_z,
           second_dir_x, second_dir_y, second_dir_z,
    input  ready
  );
  modport sink (
    input  valid, first_point_x, first_point_y, first_point_z,
           first_dir_x, first_dir_y, first_dir_z,
           second_point_x, second_point_y, second_point_z,
           second_dir_x, second_dir_y, second_dir_z,
    output ready
  );
endinterface

interface tlca_out_if #(
  parameter int POS_WIDTH = tlca_pkg::POS_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] vertex_x;
  logic signed [POS_WIDTH-1:0] vertex_y;
  logic signed [POS_WIDTH-1:0] vertex_z;
  logic                        lines_parallel;
  logic                        saturated;

  modport source (
    output valid, vertex_x, vertex_y, vertex_z, lines_parallel, saturated,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, vertex_z, lines_parallel, saturated,
    output ready
  );
endinterface

@@ design/tlca_ctl.sv @@
// ----------------------------------------------------------------------------
// tlca_ctl : pipeline valid chain and output skid control
// Shifts valid bits with the data and parks one result when stalled.
// ----------------------------------------------------------------------------
module tlca_ctl #(
  parameter int NST = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_ready,
  output tlca_pkg::ctl_t  ctl
);
  import tlca_pkg::*;

  logic [NST-1:0] valid_r, valid_nxt;
  logic           skid_v_r, skid_v_nxt;
  logic           en;
  logic           skid_ld;

  // hold the whole pipe while the skid register is occupied
  assign en      = ~skid_v_r;
  assign skid_ld = en & valid_r[NST-1] & ~out_ready;

  always_comb begin
    valid_nxt  = en ? {valid_r[NST-2:0], in_valid} : valid_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (out_ready) skid_v_nxt = 1'b0;
    end else if (skid_ld) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      skid_v_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  assign ctl.en      = en;
  assign ctl.skid_ld = skid_ld;
  assign ctl.skid_v  = skid_v_r;
  assign ctl.out_v   = skid_v_r | valid_r[NST-1];

endmodule

@@ design/tlca_mul.sv @@
// ----------------------------------------------------------------------------
// tlca_mul : two-stage signed multiplier
// Splits operand b into halves, registers both partial products, then sums.
// ----------------------------------------------------------------------------
module tlca_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  localparam int L   = BW / 2;
  localparam int HW  = BW - L;
  localparam int PRW = AW + BW;

  logic signed [AW+L:0]    pl_r, pl_nxt;
  logic signed [AW+HW-1:0] ph_r, ph_nxt;
  logic signed [PRW-1:0]   p_r, p_nxt;

  always_comb begin
    pl_nxt = (AW+L+1)'(a) * (AW+L+1)'($signed({1'b0, b[L-1:0]}));
    ph_nxt = (AW+HW)'(a) * (AW+HW)'($signed(b[BW-1:L]));
    p_nxt  = (PRW'(ph_r) <<< L) + PRW'(pl_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

@@ design/tlca_dly.sv @@
// ----------------------------------------------------------------------------
// tlca_dly : enabled delay line
// Carries side data alongside the datapath, one register per stage.
// ----------------------------------------------------------------------------
module tlca_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int k = 1; k < N; k++) tap_r[k] <= tap_r[k-1];
    end
  end

  assign q = tap_r[N-1];

endmodule

@@ design/tlca_div.sv @@
// ----------------------------------------------------------------------------
// tlca_div : pipelined dual restoring divider
// Two quotients over one shared divisor; a fit check, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module tlca_div #(
  parameter int NUMW = 78,
  parameter int DENW = 68,
  parameter int TMAG = 42,
  parameter int FB   = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NUMW-1:0] mag1,
  input  logic [NUMW-1:0] mag2,
  input  logic [DENW-1:0] den,
  output logic [TMAG-1:0] q1,
  output logic [TMAG-1:0] q2,
  output logic            ov1,
  output logic            ov2
);
  import tlca_pkg::*;

  localparam int RW = wmax(NUMW + FB, DENW + TMAG) + 1;

  logic [RW-1:0]   rem1_r [TMAG+1];
  logic [RW-1:0]   rem2_r [TMAG+1];
  logic [DENW-1:0] den_r  [TMAG+1];
  logic [TMAG-1:0] q1_r   [TMAG+1];
  logic [TMAG-1:0] q2_r   [TMAG+1];
  logic            ov1_r  [TMAG+1];
  logic            ov2_r  [TMAG+1];

  for (genvar j = 0; j <= TMAG; j++) begin : g_stage
    localparam int SH = TMAG - j;
    logic [RW-1:0]   r1_i, r2_i, t, r1_nxt, r2_nxt;
    logic [DENW-1:0] d_i;
    logic [TMAG-1:0] a1_i, a2_i, a1_nxt, a2_nxt;
    logic            o1_i, o2_i, o1_nxt, o2_nxt, ge1, ge2;

    if (j == 0) begin : g_src
      assign r1_i = RW'(mag1) << FB;
      assign r2_i = RW'(mag2) << FB;
      assign d_i  = den;
      assign a1_i = '0;
      assign a2_i = '0;
      assign o1_i = 1'b0;
      assign o2_i = 1'b0;
    end else begin : g_src
      assign r1_i = rem1_r[j-1];
      assign r2_i = rem2_r[j-1];
      assign d_i  = den_r[j-1];
      assign a1_i = q1_r[j-1];
      assign a2_i = q2_r[j-1];
      assign o1_i = ov1_r[j-1];
      assign o2_i = ov2_r[j-1];
    end

    always_comb begin
      t   = RW'(d_i) << SH;
      ge1 = (r1_i >= t);
      ge2 = (r2_i >= t);
      if (j == 0) begin
        // first step only checks that the quotient fits
        r1_nxt = r1_i;
        r2_nxt = r2_i;
        a1_nxt = a1_i;
        a2_nxt = a2_i;
        o1_nxt = ge1;
        o2_nxt = ge2;
      end else begin
        r1_nxt = ge1 ? r1_i - t : r1_i;
        r2_nxt = ge2 ? r2_i - t : r2_i;
        a1_nxt = {a1_i[TMAG-2:0], ge1};
        a2_nxt = {a2_i[TMAG-2:0], ge2};
        o1_nxt = o1_i;
        o2_nxt = o2_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem1_r[j] <= r1_nxt;
        rem2_r[j] <= r2_nxt;
        den_r[j]  <= d_i;
        q1_r[j]   <= a1_nxt;
        q2_r[j]   <= a2_nxt;
        ov1_r[j]  <= o1_nxt;
        ov2_r[j]  <= o2_nxt;
      end
    end
  end

  assign q1  = q1_r[TMAG];
  assign q2  = q2_r[TMAG];
  assign ov1 = ov1_r[TMAG];
  assign ov2 = ov2_r[TMAG];

endmodule

@@ design/two_line_closest_approach_vertex.sv @@
// ----------------------------------------------------------------------------
// two_line_closest_approach_vertex : midpoint of closest approach of 2 lines
// Dot products, determinant, two pipelined divisions and a rounded,
// saturated midpoint, streaming one line pair per clock while no result is parked.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | item
//  ---------+-----+---------------------+-------------------------------------
//  in_line  | in  | valid/ready, sink   | two lines: point and direction each
//  out_vtx  | out | valid/ready, source | vertex x/y/z, parallel, saturated
//
//  One item enters per clock while no stalled result is parked. The divider
//  first checks that each quotient fits, then resolves one quotient bit per
//  stage, over POS_WIDTH + FRAC_BITS + 3 stages in all.
//  Reset clears the valid chain and the skid register; payload is not reset.
//  A stalled result is parked in a skid register and the whole pipe holds
//  while it is occupied; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module two_line_closest_approach_vertex #(
  parameter int POS_WIDTH = tlca_pkg::POS_WIDTH_DEF,
  parameter int DIR_WIDTH = tlca_pkg::DIR_WIDTH_DEF,
  parameter int FRAC_BITS = tlca_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  tlca_in_if.sink           in_line,
  tlca_out_if.source        out_vtx
);
  import tlca_pkg::*;

  localparam int PW   = POS_WIDTH;
  localparam int DW   = DIR_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int DPW  = PW + 1;            // point difference and sum
  localparam int ABW  = 2 * DW + 2;        // a, b, c
  localparam int EW   = DPW + DW + 2;      // e1, e2
  localparam int PRW  = 2 * ABW;           // a*c, b*b
  localparam int NPW  = ABW + EW;          // b*e2 and friends
  localparam int NUMW = NPW + 1;           // numerators
  localparam int TMAG = PW + 2 + FB;       // parameter magnitude bits
  localparam int TW   = TMAG + 1;          // signed parameter
  localparam int TPW  = TW + DW;           // tau * direction
  localparam int SW   = wmax(DPW + FB, TPW) + 2;
  localparam int T    = 7 + TMAG;          // stage of the parameters
  localparam int NST  = T + 5;             // total stages
  localparam int SBW  = 3 * DPW + 6 * DW;  // point sums and directions

  localparam logic signed [SW-1:0] VMAX = {{(SW-PW+1){1'b0}}, {(PW-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN = ~VMAX;

  ctl_t ctl;

  tlca_ctl #(.NST(NST)) u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_line.valid),
    .out_ready(out_vtx.ready),
    .ctl      (ctl)
  );

  assign in_line.ready = ctl.en;

  // --------------------------------------------------------------------------
  // stage 0: differences, sums and the elementwise products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0]     p1 [3];
  logic signed [PW-1:0]     p2 [3];
  logic signed [DW-1:0]     d1 [3];
  logic signed [DW-1:0]     d2 [3];
  logic signed [DPW-1:0]    dp [3];
  logic signed [DPW-1:0]    ps [3];
  logic signed [2*DW-1:0]   pa_r [3], pa_nxt [3];
  logic signed [2*DW-1:0]   pb_r [3], pb_nxt [3];
  logic signed [2*DW-1:0]   pc_r [3], pc_nxt [3];
  logic signed [DPW+DW-1:0] pe1_r [3], pe1_nxt [3];
  logic signed [DPW+DW-1:0] pe2_r [3], pe2_nxt [3];
  logic [SBW-1:0]           sb0_r, sb0_nxt;

  always_comb begin
    p1[0] = in_line.first_point_x;
    p1[1] = in_line.first_point_y;
    p1[2] = in_line.first_point_z;
    p2[0] = in_line.second_point_x;
    p2[1] = in_line.second_point_y;
    p2[2] = in_line.second_point_z;
    d1[0] = in_line.first_dir_x;
    d1[1] = in_line.first_dir_y;
    d1[2] = in_line.first_dir_z;
    d2[0] = in_line.second_dir_x;
    d2[1] = in_line.second_dir_y;
    d2[2] = in_line.second_dir_z;
    for (int k = 0; k < 3; k++) begin
      dp[k]      = DPW'(p1[k]) - DPW'(p2[k]);
      ps[k]      = DPW'(p1[k]) + DPW'(p2[k]);
      pa_nxt[k]  = (2*DW)'(d1[k]) * (2*DW)'(d1[k]);
      pb_nxt[k]  = (2*DW)'(d1[k]) * (2*DW)'(d2[k]);
      pc_nxt[k]  = (2*DW)'(d2[k]) * (2*DW)'(d2[k]);
      pe1_nxt[k] = (DPW+DW)'(dp[k]) * (DPW+DW)'(d1[k]);
      pe2_nxt[k] = (DPW+DW)'(dp[k]) * (DPW+DW)'(d2[k]);
    end
    sb0_nxt = {ps[0], ps[1], ps[2], d1[0], d1[1], d1[2], d2[0], d2[1], d2[2]};
  end

  // --------------------------------------------------------------------------
  // stage 1: dot products
  // --------------------------------------------------------------------------
  logic signed [ABW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic signed [EW-1:0]  e1_r, e1_nxt, e2_r, e2_nxt;

  always_comb begin
    a_nxt  = ABW'(pa_r[0]) + ABW'(pa_r[1]) + ABW'(pa_r[2]);
    b_nxt  = ABW'(pb_r[0]) + ABW'(pb_r[1]) + ABW'(pb_r[2]);
    c_nxt  = ABW'(pc_r[0]) + ABW'(pc_r[1]) + ABW'(pc_r[2]);
    e1_nxt = EW'(pe1_r[0]) + EW'(pe1_r[1]) + EW'(pe1_r[2]);
    e2_nxt = EW'(pe2_r[0]) + EW'(pe2_r[1]) + EW'(pe2_r[2]);
  end

  // --------------------------------------------------------------------------
  // stages 2-3: determinant and numerator products
  // --------------------------------------------------------------------------
  logic signed [PRW-1:0] m_ac, m_bb;
  logic signed [NPW-1:0] m_be2, m_ce1, m_ae2, m_be1;

  tlca_mul #(.AW(ABW), .BW(ABW)) u_mac (
    .clk(clk), .en(ctl.en), .a(a_r), .b(c_r), .p(m_ac));
  tlca_mul #(.AW(ABW), .BW(ABW)) u_mbb (
    .clk(clk), .en(ctl.en), .a(b_r), .b(b_r), .p(m_bb));
  tlca_mul #(.AW(ABW), .BW(EW)) u_mbe2 (
    .clk(clk), .en(ctl.en), .a(b_r), .b(e2_r), .p(m_be2));
  tlca_mul #(.AW(ABW), .BW(EW)) u_mce1 (
    .clk(clk), .en(ctl.en), .a(c_r), .b(e1_r), .p(m_ce1));
  tlca_mul #(.AW(ABW), .BW(EW)) u_mae2 (
    .clk(clk), .en(ctl.en), .a(a_r), .b(e2_r), .p(m_ae2));
  tlca_mul #(.AW(ABW), .BW(EW)) u_mbe1 (
    .clk(clk), .en(ctl.en), .a(b_r), .b(e1_r), .p(m_be1));

  // --------------------------------------------------------------------------
  // stage 4: determinant (never negative) and numerators
  // stage 5: numerator magnitudes, signs and the parallel flag
  // --------------------------------------------------------------------------
  logic [PRW-1:0]         den4_r, den4_nxt;
  logic signed [NUMW-1:0] num1_r, num1_nxt, num2_r, num2_nxt;
  logic [PRW-1:0]         den5_r;
  logic [NUMW-1:0]        mag1_r, mag1_nxt, mag2_r, mag2_nxt;
  logic [2:0]             flg5_r, flg5_nxt;   // parallel, sign 1, sign 2

  always_comb begin
    den4_nxt = PRW'(m_ac - m_bb);
    num1_nxt = NUMW'(m_be2) - NUMW'(m_ce1);
    num2_nxt = NUMW'(m_ae2) - NUMW'(m_be1);
    mag1_nxt = num1_r[NUMW-1] ? NUMW'(-num1_r) : NUMW'(num1_r);
    mag2_nxt = num2_r[NUMW-1] ? NUMW'(-num2_r) : NUMW'(num2_r);
    flg5_nxt = {(den4_r == '0), num1_r[NUMW-1], num2_r[NUMW-1]};
  end

  // --------------------------------------------------------------------------
  // stages 6 .. T-1: divider, with flags and side data alongside
  // --------------------------------------------------------------------------
  logic [TMAG-1:0] q1, q2;
  logic            ov1, ov2;
  logic [2:0]      flgF;
  logic [SBW-1:0]  sbF;

  tlca_div #(.NUMW(NUMW), .DENW(PRW), .TMAG(TMAG), .FB(FB)) u_div (
    .clk (clk),
    .en  (ctl.en),
    .mag1(mag1_r),
    .mag2(mag2_r),
    .den (den5_r),
    .q1  (q1),
    .q2  (q2),
    .ov1 (ov1),
    .ov2 (ov2)
  );

  tlca_dly #(.W(3), .N(TMAG + 1)) u_dly_flg (
    .clk(clk), .en(ctl.en), .d(flg5_r), .q(flgF));

  tlca_dly #(.W(SBW), .N(T - 1)) u_dly_sb (
    .clk(clk), .en(ctl.en), .d(sb0_r), .q(sbF));

  // --------------------------------------------------------------------------
  // stage T: signed, saturated line parameters; zero for parallel lines
  // --------------------------------------------------------------------------
  logic [TMAG-1:0]      tm1, tm2;
  logic signed [TW-1:0] tau1_r, tau1_nxt, tau2_r, tau2_nxt;
  logic                 satT_r, satT_nxt, parT_r;
  logic [SBW-1:0]       sbT_r;
  logic signed [DW-1:0]  d1T [3];
  logic signed [DW-1:0]  d2T [3];

  always_comb begin
    tm1      = ov1 ? '1 : q1;
    tm2      = ov2 ? '1 : q2;
    tau1_nxt = flgF[2] ? '0 : (flgF[1] ? -TW'(tm1) : TW'(tm1));
    tau2_nxt = flgF[2] ? '0 : (flgF[0] ? -TW'(tm2) : TW'(tm2));
    satT_nxt = ~flgF[2] & (ov1 | ov2);
    for (int k = 0; k < 3; k++) begin
      d1T[k] = sbT_r[6*DW-1-k*DW -: DW];
      d2T[k] = sbT_r[3*DW-1-k*DW -: DW];
    end
  end

  // --------------------------------------------------------------------------
  // stages T+1, T+2: parameter times direction
  // --------------------------------------------------------------------------
  logic signed [TPW-1:0] pt1 [3];
  logic signed [TPW-1:0] pt2 [3];
  logic [3*DPW+1:0]      sbM;
  logic signed [DPW-1:0] psM [3];

  for (genvar k = 0; k < 3; k++) begin : g_tmul
    tlca_mul #(.AW(TW), .BW(DW)) u_mt1 (
      .clk(clk), .en(ctl.en), .a(tau1_r), .b(d1T[k]), .p(pt1[k]));
    tlca_mul #(.AW(TW), .BW(DW)) u_mt2 (
      .clk(clk), .en(ctl.en), .a(tau2_r), .b(d2T[k]), .p(pt2[k]));
  end

  tlca_dly #(.W(3*DPW+2), .N(2)) u_dly_ps (
    .clk(clk), .en(ctl.en), .d({sbT_r[SBW-1 -: 3*DPW], parT_r, satT_r}), .q(sbM));

  // --------------------------------------------------------------------------
  // stage T+3: exact sum plus half an lsb of the result
  // stage T+4: shift, clip to the position range, result register
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] s_r [3], s_nxt [3];
  logic                 parS_r, satS_r;
  logic signed [SW-1:0] sh [3];
  logic signed [PW-1:0] vtx_r [3], vtx_nxt [3];
  logic                 clip [3];
  logic                 parO_r, satO_r, satO_nxt;
  logic signed [PW-1:0] skv_r [3];
  logic                 skp_r, sks_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      psM[k] = sbM[3*DPW+1-k*DPW -: DPW];
      s_nxt[k] = (SW'(psM[k]) <<< FB) + SW'(pt1[k]) + SW'(pt2[k]) + (SW'(1) <<< FB);
      sh[k]    = s_r[k] >>> (FB + 1);
      clip[k]  = (sh[k] < VMIN) || (sh[k] > VMAX);
      if (sh[k] < VMIN) vtx_nxt[k] = VMIN[PW-1:0];
      else if (sh[k] > VMAX) vtx_nxt[k] = VMAX[PW-1:0];
      else vtx_nxt[k] = sh[k][PW-1:0];
    end
    satO_nxt = satS_r | clip[0] | clip[1] | clip[2];
  end

  // --------------------------------------------------------------------------
  // stage registers: advance together; park the result when the sink stalls
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      pc_r   <= pc_nxt;
      pe1_r  <= pe1_nxt;
      pe2_r  <= pe2_nxt;
      sb0_r  <= sb0_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      c_r    <= c_nxt;
      e1_r   <= e1_nxt;
      e2_r   <= e2_nxt;
      den4_r <= den4_nxt;
      num1_r <= num1_nxt;
      num2_r <= num2_nxt;
      den5_r <= den4_r;
      mag1_r <= mag1_nxt;
      mag2_r <= mag2_nxt;
      flg5_r <= flg5_nxt;
      tau1_r <= tau1_nxt;
      tau2_r <= tau2_nxt;
      satT_r <= satT_nxt;
      parT_r <= flgF[2];
      sbT_r  <= sbF;
      s_r    <= s_nxt;
      parS_r <= sbM[1];
      satS_r <= sbM[0];
      vtx_r  <= vtx_nxt;
      parO_r <= parS_r;
      satO_r <= satO_nxt;
    end
    if (ctl.skid_ld) begin
      skv_r <= vtx_r;
      skp_r <= parO_r;
      sks_r <= satO_r;
    end
  end

  // offer the parked item first
  assign out_vtx.valid          = ctl.out_v;
  assign out_vtx.vertex_x       = ctl.skid_v ? skv_r[0] : vtx_r[0];
  assign out_vtx.vertex_y       = ctl.skid_v ? skv_r[1] : vtx_r[1];
  assign out_vtx.vertex_z       = ctl.skid_v ? skv_r[2] : vtx_r[2];
  assign out_vtx.lines_parallel = ctl.skid_v ? skp_r : parO_r;
  assign out_vtx.saturated      = ctl.skid_v ? sks_r : satO_r;

endmodule

@@ design/tlca_chk.sv @@
// ----------------------------------------------------------------------------
// tlca_chk : port-level checks for the closest-approach vertex block
// Watches the channels for reset, back-pressure and hold behaviour.
// ----------------------------------------------------------------------------
module tlca_chk #(
  parameter int PW = tlca_pkg::POS_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [PW-1:0] vx,
  input logic [PW-1:0] vy,
  input logic [PW-1:0] vz,
  input logic          par,
  input logic          sat
);

  // nothing offered straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // input refused only while a result is waiting
  a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input refused with no result pending");

  // input reopens only after the sink took an item
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) && $past(rst_n) |-> $past(out_ready))
    else $error("input reopened without a delivery");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({vx, vy, vz, par, sat}))
    else $error("stalled result changed");

  // offered input stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input withdrawn before acceptance");

endmodule

bind two_line_closest_approach_vertex tlca_chk #(.PW(POS_WIDTH)) u_tlca_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_line.valid),
  .in_ready (in_line.ready),
  .out_valid(out_vtx.valid),
  .out_ready(out_vtx.ready),
  .vx       (out_vtx.vertex_x),
  .vy       (out_vtx.vertex_y),
  .vz       (out_vtx.vertex_z),
  .par      (out_vtx.lines_parallel),
  .sat      (out_vtx.saturated)
);
